@@ sv/smsc_pkg.sv @@
// ----------------------------------------------------------------------------
// smsc_pkg
// Shared types, constants and the half-step coil table for the move sequencer.
// ----------------------------------------------------------------------------
package smsc_pkg;

    localparam int unsigned INTERVAL_W = 8;
    localparam int unsigned STEPS_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned COILS_W    = 4;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd2;
    localparam logic [STEPS_W-1:0]    STEPS_RESET    = 16'd1024;
    localparam logic [INTERVAL_W-1:0] TICKS_SAT      = '1;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic REG_STEP_INTERVAL = 1'b0;
    localparam logic REG_MOVE_STEPS    = 1'b1;

    typedef struct packed {
        logic action;
        logic wanted_position;
    } t_item;

    typedef struct packed {
        logic               busy_res;
        logic               at_position;
        logic               stepped;
        logic [COILS_W-1:0] coils;
    } t_result;

    function automatic logic [COILS_W-1:0] f_phase_coils(input logic [PHASE_W-1:0] ph);
        logic [COILS_W-1:0] c;
        begin
            unique case (ph)
                3'd0: c = 4'h1;
                3'd1: c = 4'h3;
                3'd2: c = 4'h2;
                3'd3: c = 4'h6;
                3'd4: c = 4'h4;
                3'd5: c = 4'hC;
                3'd6: c = 4'h8;
                3'd7: c = 4'h9;
                default: c = 4'h0;
            endcase
            return c;
        end
    endfunction

endpackage

@@ sv/smsc_in_stage.sv @@
// ----------------------------------------------------------------------------
// smsc_in_stage
// Input register: holds one request until the step logic takes it.
// ----------------------------------------------------------------------------
module smsc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  smsc_pkg::t_item      i_item,
    input  logic                 i_take,
    output logic                 o_valid,
    output smsc_pkg::t_item      o_item
);
    import smsc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/smsc_step_core.sv @@
// ----------------------------------------------------------------------------
// smsc_step_core
// Move state, configuration registers and the per-request update logic.
// ----------------------------------------------------------------------------
module smsc_step_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [smsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_fire,
    input  smsc_pkg::t_item                   i_item,
    output smsc_pkg::t_result                 o_result
);
    import smsc_pkg::*;

    logic [INTERVAL_W-1:0] r_interval;
    logic [STEPS_W-1:0]    r_move_steps;

    logic [PHASE_W-1:0]    r_phase,  n_phase;
    logic                  r_rev,    n_rev;
    logic [STEPS_W-1:0]    r_done,   n_done;
    logic                  r_moving, n_moving;
    logic                  r_reached, n_reached;
    logic                  r_target, n_target;
    logic                  r_dest,   n_dest;
    logic [INTERVAL_W-1:0] r_ticks,  n_ticks;
    logic [COILS_W-1:0]    r_coils,  n_coils;
    logic                  n_stepped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= INTERVAL_RESET;
            r_move_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEP_INTERVAL: r_interval   <= i_cfg_data[INTERVAL_W-1:0];
                REG_MOVE_STEPS:    r_move_steps <= i_cfg_data[STEPS_W-1:0];
                default:           r_interval   <= r_interval;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_rev     = r_rev;
        n_done    = r_done;
        n_moving  = r_moving;
        n_reached = r_reached;
        n_target  = r_target;
        n_dest    = r_dest;
        n_ticks   = r_ticks;
        n_coils   = r_coils;
        n_stepped = 1'b0;
        if (i_item.action == ACT_SET) begin
            n_target = i_item.wanted_position;
        end else begin
            if (r_ticks != TICKS_SAT) begin
                n_ticks = r_ticks + 1'b1;
            end
            if (!r_moving && (r_reached != r_target)) begin
                n_done   = '0;
                n_dest   = r_target;
                n_rev    = !r_target;
                n_moving = 1'b1;
            end
            if (n_moving) begin
                if ((n_done < r_move_steps) && (n_ticks >= r_interval)) begin
                    n_ticks   = '0;
                    n_coils   = f_phase_coils(r_phase);
                    n_phase   = n_rev ? (r_phase - 1'b1) : (r_phase + 1'b1);
                    n_done    = n_done + 1'b1;
                    n_stepped = 1'b1;
                end
                if (n_done >= r_move_steps) begin
                    n_reached = n_dest;
                    n_moving  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_rev     <= 1'b0;
            r_done    <= '0;
            r_moving  <= 1'b0;
            r_reached <= 1'b0;
            r_target  <= 1'b0;
            r_dest    <= 1'b0;
            r_ticks   <= TICKS_SAT;
            r_coils   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_rev     <= n_rev;
            r_done    <= n_done;
            r_moving  <= n_moving;
            r_reached <= n_reached;
            r_target  <= n_target;
            r_dest    <= n_dest;
            r_ticks   <= n_ticks;
            r_coils   <= n_coils;
        end
    end

    assign o_result.coils       = n_coils;
    assign o_result.stepped     = n_stepped;
    assign o_result.at_position = n_reached;
    assign o_result.busy_res    = n_moving;

endmodule

@@ sv/smsc_out_stage.sv @@
// ----------------------------------------------------------------------------
// smsc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module smsc_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  smsc_pkg::t_result    i_result,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output smsc_pkg::t_result    o_result
);
    import smsc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ sv/stepper_move_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// stepper_move_sequencer_core
// Two-position half-step stepper sequencer with stream in and out.
// ----------------------------------------------------------------------------
// Each request (a 1 ms tick or a set-position command) gives exactly one
// result. A request is registered, updated through the combinational move
// logic and lands in the result register, so one request per cycle is
// sustained while m_tready stays high. m_tvalid rises when the result is
// loaded into the result register, where it is held until taken. The result
// register and the input register are both one deep; input stalls only when
// both are full and m_tready is low. Configuration writes take effect at once.
module stepper_move_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [smsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] wanted_position
    input  logic                             s_tuser,   // [0] action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata    // [3:0] coils, [4] stepped,
                                                        // [5] at_position, [6] busy_res
);
    import smsc_pkg::*;

    t_item   w_in_item;
    t_item   w_reg_item;
    t_result w_calc;
    t_result w_out;
    logic    w_reg_valid;
    logic    w_out_free;
    logic    w_fire;

    assign w_in_item.action          = s_tuser;
    assign w_in_item.wanted_position = s_tdata[0];
    assign w_fire                    = w_reg_valid && w_out_free;

    smsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_valid (w_reg_valid),
        .o_item  (w_reg_item)
    );

    smsc_step_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_item     (w_reg_item),
        .o_result   (w_calc)
    );

    smsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_calc),
        .o_free   (w_out_free),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (w_out)
    );

    assign m_tdata = {1'b0, w_out};

endmodule
